// ===== rtl/bos_pkg.sv =====
`default_nettype none

package bos_pkg;

    localparam int LANE_W      = 16;
    localparam int DELTA_W     = 17;
    localparam int OBS_W       = 24;
    localparam int TOT_W       = 48;
    localparam int BASE_W      = TOT_W + 1;
    localparam int LN_W        = 11;
    localparam int LABEL_W     = 4;
    localparam int LABEL_SLOTS = 16;
    localparam int COUNT_W     = 9;
    localparam int COUNT_LIMIT = 511;
    localparam int PEN_W       = 16;

    localparam logic [PEN_W-1:0] PENALTY_RESET = 16'd5120;
    localparam longint unsigned LN2_Q28 = 64'd186065280;

    typedef struct packed {
        logic                      last;
        logic signed [DELTA_W-1:0] delta;
        logic signed [BASE_W-1:0]  base;
    } t_b_word;

    // Natural logarithm in Q3.8, rounded to nearest, for n of one or more.
    function automatic logic [LN_W-1:0] ln_q8(input int unsigned n);
        int unsigned     k;
        int unsigned     i;
        longint unsigned nn;
        longint unsigned x;
        longint unsigned frac;
        longint unsigned l;
        longint unsigned p;
        nn = 64'(n);
        k = 0;
        for (i = 1; i <= 20; i++) begin
            if ((nn >> i) != 64'd0) begin
                k = i;
            end
        end
        x = (nn << 30) >> k;
        frac = 64'd0;
        for (i = 0; i < 30; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd1 << 31)) begin
                frac = frac | 64'd1;
                x = x >> 1;
            end
        end
        l = (64'(k) << 30) | frac;
        p = l * LN2_Q28;
        return LN_W'((p + (64'd1 << 49)) >> 50);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/board_observation_scorer_core.sv =====
// Board observation scorer: scores one candidate board, one square per input word.
// Input channel (i_in_valid / o_in_stall): a word is taken at a rising edge with
// i_in_valid high and o_in_stall low. Each word carries the thirteen label costs, the
// candidate and parent labels of one square, and on the final square also the self-loop
// flag, the parent score and the parent's child count.
// Output channel (o_out_valid / i_out_stall): one word per board, holding the saturated
// total score and the observation sum; it is taken when o_out_valid is high and
// i_out_stall is low.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): writes the Q8.8 move
// penalty; the user must write it only while no board is in progress (not enforced).
// Throughput is one square per cycle while o_in_stall stays low. The result word passes
// through the three register stages (input, label search with logarithm lookup,
// accumulator).
// Reset empties the pipeline, clears the running sum and sets the move penalty to 20.0.
// While the receiver stalls, the result word is held; further squares are still taken
// until the next final square reaches the accumulator, after which o_in_stall rises.
`default_nettype none

module board_observation_scorer_core #(
    parameter int LABEL_COUNT  = 13,
    parameter int COST_BITS    = 16,
    parameter int MAX_CHILDREN = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [63:0]                       i_costs_low,
    input  wire logic [63:0]                       i_costs_mid,
    input  wire logic [63:0]                       i_costs_high,
    input  wire logic signed [15:0]                i_cost_twelve,
    input  wire logic [3:0]                        i_square_label,
    input  wire logic [3:0]                        i_parent_label,
    input  wire logic                              i_last_square,
    input  wire logic                              i_self_loop,
    input  wire logic signed [47:0]                i_parent_score,
    input  wire logic [8:0]                        i_sibling_count,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [47:0]                     o_total_score,
    output logic signed [23:0]                     o_observation_score,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [15:0]                       i_cfg_data
);

    logic                               r_a_valid;
    logic [63:0]                        r_a_costs_low;
    logic [63:0]                        r_a_costs_mid;
    logic [63:0]                        r_a_costs_high;
    logic signed [15:0]                 r_a_cost_twelve;
    logic [3:0]                         r_a_square_label;
    logic [3:0]                         r_a_parent_label;
    logic                               r_a_last;
    logic                               r_a_self_loop;
    logic signed [47:0]                 r_a_parent_score;
    logic [8:0]                         r_a_sibling_count;
    logic [bos_pkg::PEN_W-1:0]          r_move_penalty;
    logic                               b_free;
    logic                               b_valid;
    bos_pkg::t_b_word                   b_word;
    logic                               c_take;
    logic                               in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_a_valid && !b_free;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_penalty <= bos_pkg::PENALTY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_move_penalty <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (b_free) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_costs_low     <= i_costs_low;
            r_a_costs_mid     <= i_costs_mid;
            r_a_costs_high    <= i_costs_high;
            r_a_cost_twelve   <= i_cost_twelve;
            r_a_square_label  <= i_square_label;
            r_a_parent_label  <= i_parent_label;
            r_a_last          <= i_last_square;
            r_a_self_loop     <= i_self_loop;
            r_a_parent_score  <= i_parent_score;
            r_a_sibling_count <= i_sibling_count;
        end
    end

    bos_label_stage #(
        .LABEL_COUNT  (LABEL_COUNT),
        .COST_BITS    (COST_BITS),
        .MAX_CHILDREN (MAX_CHILDREN)
    ) u_label_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_a_valid),
        .i_costs_low     (r_a_costs_low),
        .i_costs_mid     (r_a_costs_mid),
        .i_costs_high    (r_a_costs_high),
        .i_cost_twelve   (r_a_cost_twelve),
        .i_square_label  (r_a_square_label),
        .i_parent_label  (r_a_parent_label),
        .i_last_square   (r_a_last),
        .i_self_loop     (r_a_self_loop),
        .i_parent_score  (r_a_parent_score),
        .i_sibling_count (r_a_sibling_count),
        .i_move_penalty  (r_move_penalty),
        .i_take          (c_take),
        .o_free          (b_free),
        .o_valid         (b_valid),
        .o_word          (b_word)
    );

    bos_accum u_accum (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (b_valid),
        .i_word              (b_word),
        .o_take              (c_take),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_total_score       (o_total_score),
        .o_observation_score (o_observation_score)
    );

endmodule

`default_nettype wire

// ===== rtl/bos_label_stage.sv =====
`default_nettype none

module bos_label_stage #(
    parameter int LABEL_COUNT  = 13,
    parameter int COST_BITS    = 16,
    parameter int MAX_CHILDREN = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic [63:0]                         i_costs_low,
    input  wire logic [63:0]                         i_costs_mid,
    input  wire logic [63:0]                         i_costs_high,
    input  wire logic signed [bos_pkg::LANE_W-1:0]   i_cost_twelve,
    input  wire logic [bos_pkg::LABEL_W-1:0]         i_square_label,
    input  wire logic [bos_pkg::LABEL_W-1:0]         i_parent_label,
    input  wire logic                                i_last_square,
    input  wire logic                                i_self_loop,
    input  wire logic signed [bos_pkg::TOT_W-1:0]    i_parent_score,
    input  wire logic [bos_pkg::COUNT_W-1:0]         i_sibling_count,
    input  wire logic [bos_pkg::PEN_W-1:0]           i_move_penalty,
    input  wire logic                                i_take,
    output logic                                     o_free,
    output logic                                     o_valid,
    output bos_pkg::t_b_word                         o_word
);

    localparam int CW      = (COST_BITS < bos_pkg::LANE_W) ? COST_BITS : bos_pkg::LANE_W;
    localparam int TBL     = (MAX_CHILDREN < bos_pkg::COUNT_LIMIT) ? MAX_CHILDREN
                                                                   : bos_pkg::COUNT_LIMIT;
    localparam int IDX_W   = $clog2(TBL);
    localparam int CNT_W   = bos_pkg::COUNT_W;
    localparam int LBL_W   = bos_pkg::LABEL_W;
    localparam int SLOTS   = bos_pkg::LABEL_SLOTS;
    localparam int DW      = bos_pkg::DELTA_W;
    localparam int BW      = bos_pkg::BASE_W;
    localparam int LW      = bos_pkg::LN_W;
    localparam int PW      = bos_pkg::PEN_W;
    localparam int TW      = bos_pkg::TOT_W;
    localparam int LANE    = bos_pkg::LANE_W;

    typedef struct packed {
        logic                 ok;
        logic signed [CW-1:0] cost;
        logic [LBL_W-1:0]     label;
    } t_node;

    function automatic t_node pick(input t_node a, input t_node b);
        if (b.ok && (!a.ok || ($signed(b.cost) < $signed(a.cost)))) begin
            return b;
        end
        return a;
    endfunction

    logic [LANE-1:0]      lane [SLOTS];
    logic signed [CW-1:0] cost [SLOTS];
    logic                 label_ok [SLOTS];
    t_node                lvl0 [16];
    t_node                lvl1 [8];
    t_node                lvl2 [4];
    t_node                lvl3 [2];
    t_node                best;
    logic signed [CW-1:0] cand_cost;
    logic signed [DW-1:0] cand_ext;
    logic                 twice;
    logic [LW-1:0]        ln_rom [TBL];
    logic [CNT_W-1:0]     cnt;
    logic [CNT_W-1:0]     cnt_m1;
    logic [LW-1:0]        ln_val;
    logic [PW-1:0]        pen;
    bos_pkg::t_b_word     n_word;
    logic                 r_valid;
    bos_pkg::t_b_word     r_word;

    for (genvar g = 0; g < TBL; g++) begin : g_ln_rom
        assign ln_rom[g] = bos_pkg::ln_q8(32'(g + 1));
    end

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            lane[l]     = i_costs_low[LANE*l +: LANE];
            lane[l + 4] = i_costs_mid[LANE*l +: LANE];
            lane[l + 8] = i_costs_high[LANE*l +: LANE];
        end
        lane[12] = LANE'(i_cost_twelve);
        for (int l = 13; l < SLOTS; l++) begin
            lane[l] = '0;
        end
        for (int l = 0; l < SLOTS; l++) begin
            cost[l]        = lane[l][CW-1:0];
            label_ok[l]    = (l < LABEL_COUNT);
            lvl0[l].ok     = label_ok[l];
            lvl0[l].cost   = cost[l];
            lvl0[l].label  = LBL_W'(l);
        end
        for (int j = 0; j < 8; j++) begin
            lvl1[j] = pick(lvl0[2*j], lvl0[2*j + 1]);
        end
        for (int j = 0; j < 4; j++) begin
            lvl2[j] = pick(lvl1[2*j], lvl1[2*j + 1]);
        end
        for (int j = 0; j < 2; j++) begin
            lvl3[j] = pick(lvl2[2*j], lvl2[2*j + 1]);
        end
        best = pick(lvl3[0], lvl3[1]);

        cand_cost = cost[i_square_label];
        cand_ext  = {{(DW - CW){cand_cost[CW-1]}}, cand_cost};
        twice     = (i_square_label != i_parent_label) || (i_square_label != best.label);

        cnt = i_sibling_count;
        if (cnt == '0) begin
            cnt = CNT_W'(1);
        end else if (cnt > CNT_W'(TBL)) begin
            cnt = CNT_W'(TBL);
        end
        cnt_m1 = cnt - CNT_W'(1);
        ln_val = ln_rom[cnt_m1[IDX_W-1:0]];
        pen    = i_self_loop ? '0 : i_move_penalty;

        n_word.last = i_last_square;
        if (!label_ok[i_square_label]) begin
            n_word.delta = '0;
        end else if (twice) begin
            n_word.delta = cand_ext + cand_ext;
        end else begin
            n_word.delta = cand_ext;
        end
        n_word.base = {i_parent_score[TW-1], i_parent_score}
                    + {{(BW - LW){1'b0}}, ln_val}
                    + {{(BW - PW){1'b0}}, pen};
    end

    assign o_free  = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bos_accum.sv =====
`default_nettype none

module bos_accum (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire bos_pkg::t_b_word                  i_word,
    output logic                                   o_take,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output logic signed [bos_pkg::TOT_W-1:0]       o_total_score,
    output logic signed [bos_pkg::OBS_W-1:0]       o_observation_score
);

    localparam int OW = bos_pkg::OBS_W;
    localparam int DW = bos_pkg::DELTA_W;
    localparam int BW = bos_pkg::BASE_W;
    localparam int TW = bos_pkg::TOT_W;

    logic                 out_free;
    logic signed [OW:0]   sum_ext;
    logic signed [OW-1:0] n_obs;
    logic signed [BW:0]   total_ext;
    logic signed [TW-1:0] n_total;
    logic signed [OW-1:0] r_sum;
    logic                 r_out_valid;
    logic signed [TW-1:0] r_total;
    logic signed [OW-1:0] r_obs;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_take   = i_valid && (!i_word.last || out_free);

    always_comb begin
        sum_ext = {r_sum[OW-1], r_sum} + {{(OW + 1 - DW){i_word.delta[DW-1]}}, i_word.delta};
        if (sum_ext[OW] != sum_ext[OW-1]) begin
            n_obs = {sum_ext[OW], {(OW - 1){!sum_ext[OW]}}};
        end else begin
            n_obs = sum_ext[OW-1:0];
        end

        total_ext = {{(BW + 1 - OW){n_obs[OW-1]}}, n_obs} + {i_word.base[BW-1], i_word.base};
        if ((total_ext[BW] != total_ext[BW-1]) || (total_ext[BW-1] != total_ext[TW-1])) begin
            n_total = {total_ext[BW], {(TW - 1){!total_ext[BW]}}};
        end else begin
            n_total = total_ext[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (o_take) begin
            r_sum <= i_word.last ? '0 : n_obs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_take && i_word.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_word.last) begin
            r_total <= n_total;
            r_obs   <= n_obs;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_total_score       = r_total;
    assign o_observation_score = r_obs;

`ifndef NO_ASSERTIONS
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_word.last) |=> (r_sum == '0))
        else $error("Running sum was not cleared after the final square.");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_take && i_word.last))
        else $error("Result word appeared without a final square.");

    a_square_never_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_word.last) |-> o_take)
        else $error("A square that is not final was held back.");
`endif

endmodule

`default_nettype wire

// ===== tb/board_observation_scorer_core_checker.sv =====
`default_nettype none

module board_observation_scorer_core_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [63:0]        i_costs_low,
    input  wire logic [63:0]        i_costs_mid,
    input  wire logic [63:0]        i_costs_high,
    input  wire logic signed [15:0] i_cost_twelve,
    input  wire logic [3:0]         i_square_label,
    input  wire logic [3:0]         i_parent_label,
    input  wire logic               i_last_square,
    input  wire logic               i_self_loop,
    input  wire logic signed [47:0] i_parent_score,
    input  wire logic [8:0]         i_sibling_count,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic signed [47:0] i_total_score,
    input  wire logic signed [23:0] i_observation_score,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [15:0]        i_cfg_data,
    output int                      o_mismatches,
    output int                      o_outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LABELS      = 13;
    localparam int     CHILD_LIMIT = 256;
    localparam longint OBS_HI      = 8388607;
    localparam longint OBS_LO      = -8388608;
    localparam longint TOT_HI      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint TOT_LO      = -TOT_HI - 1;

    typedef struct {
        logic signed [47:0] total;
        logic signed [23:0] obs;
    } t_board_score;

    logic [15:0]  move_penalty;
    longint       board_sum;
    t_board_score board_scores[$];

    function automatic longint lane_cost(input int unsigned label);
        logic [15:0] lane;
        if (label < 4) begin
            lane = i_costs_low[label*16 +: 16];
        end else if (label < 8) begin
            lane = i_costs_mid[(label-4)*16 +: 16];
        end else if (label < 12) begin
            lane = i_costs_high[(label-8)*16 +: 16];
        end else if (label == 12) begin
            lane = i_cost_twelve;
        end else begin
            return 0;
        end
        return longint'($signed(lane));
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Natural logarithm in Q8.8: a base-2 logarithm with 30 fraction bits found by
    // repeated squaring, scaled by ln 2 and rounded to nearest.
    function automatic longint ln_q8_8(input int unsigned n);
        int unsigned     k;
        longint unsigned x;
        longint unsigned frac;
        longint unsigned lg;
        longint unsigned prod;
        k = 0;
        while (k < 20 && (n >> (k + 1)) != 0) begin
            k++;
        end
        x = 64'(n);
        x = (x << 30) >> k;
        frac = 0;
        for (int i = 0; i < 30; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= 64'h8000_0000) begin
                frac = frac | 64'd1;
                x = x >> 1;
            end
        end
        lg = (64'(k) << 30) | frac;
        prod = lg * 64'd186065280;
        return longint'((prod + (64'd1 << 49)) >> 50);
    endfunction

    always @(posedge i_clk) begin : watch
        t_board_score want;
        longint       c;
        longint       best;
        longint       total;
        int unsigned  seen;
        int unsigned  sq;
        int unsigned  kids;
        if (!i_rst_n) begin
            move_penalty = bos_pkg::PENALTY_RESET;
            board_sum = 0;
            board_scores.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (board_scores.size() == 0) begin
                    $display("%0t: unexpected result word: expected none, actual total %0d obs %0d",
                             $time, i_total_score, i_observation_score);
                    o_mismatches++;
                end else begin
                    want = board_scores.pop_front();
                    if (want.total !== i_total_score) begin
                        $display("%0t: total_score mismatch: expected %0d, actual %0d",
                                 $time, want.total, i_total_score);
                        o_mismatches++;
                    end
                    if (want.obs !== i_observation_score) begin
                        $display("%0t: observation_score mismatch: expected %0d, actual %0d",
                                 $time, want.obs, i_observation_score);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                best = lane_cost(0);
                seen = 0;
                for (int l = 1; l < LABELS; l++) begin
                    c = lane_cost(l);
                    if (c < best) begin
                        best = c;
                        seen = l;
                    end
                end
                sq = i_square_label;
                if (sq < LABELS) begin
                    c = lane_cost(sq);
                    board_sum = clamp(board_sum + c, OBS_LO, OBS_HI);
                    if (sq != i_parent_label || sq != seen) begin
                        board_sum = clamp(board_sum + c, OBS_LO, OBS_HI);
                    end
                end
                if (i_last_square) begin
                    kids = i_sibling_count;
                    if (kids == 0) begin
                        kids = 1;
                    end
                    if (kids > CHILD_LIMIT) begin
                        kids = CHILD_LIMIT;
                    end
                    total = board_sum + ln_q8_8(kids) + longint'(i_parent_score);
                    if (!i_self_loop) begin
                        total = total + longint'(move_penalty);
                    end
                    total = clamp(total, TOT_LO, TOT_HI);
                    want.total = total[47:0];
                    want.obs = board_sum[23:0];
                    board_scores.insert(board_scores.size(), want);
                    board_sum = 0;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                move_penalty = i_cfg_data;
            end
        end
        o_outstanding = board_scores.size();
    end

endmodule

`default_nettype wire

// ===== tb/board_observation_scorer_core_tb.sv =====
`default_nettype none

module board_observation_scorer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0]        low;
        logic [63:0]        mid;
        logic [63:0]        high;
        logic signed [15:0] twelve;
        logic [3:0]         label;
        logic [3:0]         parent;
        logic               last;
        logic               self_loop;
        logic signed [47:0] parent_score;
        logic [8:0]         siblings;
    } t_square;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [63:0]        costs_low = '0;
    logic [63:0]        costs_mid = '0;
    logic [63:0]        costs_high = '0;
    logic signed [15:0] cost_twelve = '0;
    logic [3:0]         square_label = '0;
    logic [3:0]         parent_label = '0;
    logic               last_square = 1'b0;
    logic               self_loop = 1'b0;
    logic signed [47:0] parent_score = '0;
    logic [8:0]         sibling_count = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [47:0] total_score;
    logic signed [23:0] observation_score;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = '0;
    int                 mismatches;
    int                 outstanding;
    int                 squares_sent = 0;
    int                 hold_left = 0;

    board_observation_scorer_core u_top (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_costs_low         (costs_low),
        .i_costs_mid         (costs_mid),
        .i_costs_high        (costs_high),
        .i_cost_twelve       (cost_twelve),
        .i_square_label      (square_label),
        .i_parent_label      (parent_label),
        .i_last_square       (last_square),
        .i_self_loop         (self_loop),
        .i_parent_score      (parent_score),
        .i_sibling_count     (sibling_count),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_total_score       (total_score),
        .o_observation_score (observation_score),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_data          (cfg_data)
    );

    board_observation_scorer_core_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_costs_low         (costs_low),
        .i_costs_mid         (costs_mid),
        .i_costs_high        (costs_high),
        .i_cost_twelve       (cost_twelve),
        .i_square_label      (square_label),
        .i_parent_label      (parent_label),
        .i_last_square       (last_square),
        .i_self_loop         (self_loop),
        .i_parent_score      (parent_score),
        .i_sibling_count     (sibling_count),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_total_score       (total_score),
        .i_observation_score (observation_score),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_data          (cfg_data),
        .o_mismatches        (mismatches),
        .o_outstanding       (outstanding)
    );

    initial begin
        forever begin
            #5 clk = ~clk;
        end
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_square with_lane(input t_square s, input int label,
                                          input logic [15:0] v);
        if (label < 4) begin
            s.low[label*16 +: 16] = v;
        end else if (label < 8) begin
            s.mid[(label-4)*16 +: 16] = v;
        end else if (label < 12) begin
            s.high[(label-8)*16 +: 16] = v;
        end else begin
            s.twelve = v;
        end
        return s;
    endfunction

    function automatic t_square all_lanes(input t_square s, input logic [15:0] v);
        s.low = {4{v}};
        s.mid = {4{v}};
        s.high = {4{v}};
        s.twelve = v;
        return s;
    endfunction

    function automatic logic [15:0] random_lane();
        case ($urandom_range(0, 39))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_square random_square();
        t_square s;
        longint  pv;
        for (int l = 0; l < 13; l++) begin
            s = with_lane(s, l, random_lane());
        end
        s.label = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
                                               : 4'($urandom_range(0, 12));
        s.parent = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(13, 15))
                                                : 4'($urandom_range(0, 12));
        s.last = 1'b0;
        s.self_loop = 1'($urandom);
        s.siblings = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                  : 9'($urandom_range(1, 256));
        case ($urandom_range(0, 19))
            0: s.parent_score = 48'sh7FFF_FFFF_FFFF;
            1: s.parent_score = 48'sh8000_0000_0000;
            2: s.parent_score = '0;
            3: s.parent_score = '1;
            4, 5, 6, 7, 8, 9, 10, 11: begin
                pv = longint'($urandom_range(0, 2097152)) - 1048576;
                s.parent_score = pv[47:0];
            end
            default: s.parent_score = 48'({$urandom, $urandom});
        endcase
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    task automatic offer_square(input t_square s);
        costs_low <= s.low;
        costs_mid <= s.mid;
        costs_high <= s.high;
        cost_twelve <= s.twelve;
        square_label <= s.label;
        parent_label <= s.parent;
        last_square <= s.last;
        self_loop <= s.self_loop;
        parent_score <= s.parent_score;
        sibling_count <= s.siblings;
        in_valid <= 1'b1;
        do begin
            @(posedge clk);
        end while (in_stall);
        squares_sent++;
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_penalty(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Flavours: 0 random costs, 1 all costs at the top, 2 all costs at the bottom,
    // 3 a planted lowest cost that the candidate or parent label often matches.
    task automatic send_board(input int len, input int flavour, input bit no_gaps);
        t_square s;
        int      mark;
        for (int i = 0; i < len; i++) begin
            s = random_square();
            if (flavour == 1) begin
                s = all_lanes(s, 16'h7FFF);
            end else if (flavour == 2) begin
                s = all_lanes(s, 16'h8000);
            end else if (flavour == 3) begin
                mark = $urandom_range(0, 12);
                s = with_lane(s, mark, 16'h8000);
                case ($urandom_range(0, 3))
                    0, 1: begin
                        s.label = 4'(mark);
                        s.parent = 4'(mark);
                    end
                    2: s.label = 4'(mark);
                    default: s.parent = s.label;
                endcase
            end
            s.last = (i == len - 1);
            offer_square(s);
            if (!no_gaps) begin
                pause_sender(pick_gap());
            end
        end
    endtask

    task automatic random_board();
        int r;
        int len;
        int flavour;
        r = $urandom_range(0, 99);
        flavour = $urandom_range(0, 99) < 55 ? 0 : ($urandom_range(0, 7) < 7 ? 3 : 1);
        if (r < 65) begin
            len = $urandom_range(1, 6);
        end else if (r < 85) begin
            len = $urandom_range(7, 40);
        end else if (r < 97) begin
            len = 64;
        end else begin
            len = $urandom_range(100, 150);
            flavour = $urandom_range(1, 2);
        end
        send_board(len, flavour, $urandom_range(0, 3) == 0);
    endtask

    initial begin
        int mode;
        int left;
        int burst;
        mode = 0;
        left = 0;
        burst = 0;
        forever begin
            @(posedge clk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 80);
            end
            left--;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                out_stall <= 1'b1;
            end else if (mode == 0) begin
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < 2) begin
                burst = $urandom_range(10, 40);
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < (mode == 1 ? 25 : 60));
            end
        end
    end

    initial begin
        t_square z;
        t_square s;
        z = '0;
        z.siblings = 9'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        s = z;
        s.last = 1'b1;
        s.self_loop = 1'b1;
        offer_square(s);

        s = all_lanes(z, 16'h7FFF);
        s.label = 4'd12;
        s.parent = 4'd12;
        s.last = 1'b1;
        s.siblings = 9'd256;
        s.parent_score = 48'sh7FFF_FFFF_FFFF;
        offer_square(s);

        s = all_lanes(z, 16'h8000);
        s.label = 4'd4;
        s.parent = 4'd9;
        s.last = 1'b1;
        s.self_loop = 1'b1;
        s.siblings = 9'd0;
        s.parent_score = 48'sh8000_0000_0000;
        offer_square(s);

        s = with_lane(z, 7, 16'hFF00);
        s.label = 4'd7;
        s.parent = 4'd7;
        offer_square(s);
        s.parent = 4'd6;
        s.last = 1'b1;
        s.siblings = 9'd511;
        offer_square(s);

        s = all_lanes(z, 16'h0100);
        s = with_lane(s, 3, 16'h8001);
        s = with_lane(s, 10, 16'h8001);
        s.label = 4'd10;
        s.parent = 4'd10;
        offer_square(s);
        s.label = 4'd3;
        s.parent = 4'd3;
        s.last = 1'b1;
        s.siblings = 9'd2;
        offer_square(s);

        s = all_lanes(z, 16'h1234);
        s.label = 4'd13;
        offer_square(s);
        s.label = 4'd15;
        s.last = 1'b1;
        s.siblings = 9'd255;
        s.parent_score = '1;
        offer_square(s);

        s = with_lane(z, 12, 16'h8000);
        s.label = 4'd12;
        s.parent = 4'd12;
        s.last = 1'b1;
        s.siblings = 9'd3;
        offer_square(s);

        s = z;
        s.parent = 4'd15;
        s.last = 1'b1;
        s.siblings = 9'd257;
        offer_square(s);
        drain(4);

        for (int p = 0; p < 6; p++) begin
            case (p)
                1: write_penalty(16'h0000);
                2: write_penalty(16'hFFFF);
                3: write_penalty(16'($urandom));
                4: write_penalty(16'h0001);
                5: write_penalty(16'h8000);
                default: ;
            endcase
            if (p == 1) begin
                send_board(140, 1, 1'b0);
            end
            if (p == 2) begin
                // The receiver holds off while one-square boards keep coming, so the
                // block fills and stalls its input.
                hold_left = 200;
                repeat (30) send_board(1, 0, 1'b1);
            end
            if (p == 3) begin
                send_board(140, 2, 1'b0);
            end
            while (squares_sent < 40 + 135 * (p + 1)) begin
                random_board();
            end
            drain(4);
        end

        drain(8);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
